// File: rtl/core/rpn_pkg.sv
// Shared types and codes for the RPN stack calculator.
// Holds the transaction structs, operation and status codes, and the ALU request.
// No dependencies.
`default_nettype none

package rpn_pkg;

    localparam int OP_WIDTH     = 3;
    localparam int STATUS_WIDTH = 2;
    localparam int VALUE_WIDTH  = 32;
    localparam int DEPTH_WIDTH  = 7;

    localparam logic [OP_WIDTH-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_WIDTH-1:0] OP_REM  = 3'd5;

    localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [OP_WIDTH-1:0]           operation;
        logic signed [VALUE_WIDTH-1:0] push_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] top_value;
        logic [DEPTH_WIDTH-1:0]        stack_depth;
        logic [STATUS_WIDTH-1:0]       status;
    } rsp_item_t;

    typedef struct packed {
        logic                start;
        logic [OP_WIDTH-1:0] op;
    } alu_req_t;

endpackage

`default_nettype wire

// File: rtl/core/rpn_stack_calculator.sv
// RPN stack calculator top level: stack memory, control sequencer, result register.
// Depends on rpn_pkg and rpn_alu.
//
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd_data) carries one push or arithmetic
//   operation per transaction; rsp channel returns one transaction per command
//   with the new top of stack, the depth and a status code.
//   One command is in work at a time; cmd_stall is high from acceptance until
//   its result is loaded into the output register.
//   From acceptance, push, no-op and underflow go straight to the emit state;
//   divide by zero passes through the read state first; add, sub, mul, div and
//   rem pass through the read and calc states and wait for the serial ALU,
//   whose loop works one bit per cycle. The emit state waits while a stalled
//   response holds the output register, and cmd_stall stays high meanwhile.
//   The top of stack is kept in a register; the entry below it comes from a
//   stack memory with one write port and one registered read port.
//   Reset empties the stack at once (depth 0, top 0); memory contents are not
//   cleared. A stalled response holds its data; the next command may be
//   accepted meanwhile, and its result waits until the output register frees.
`default_nettype none

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire rpn_pkg::cmd_item_t cmd_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rpn_pkg::rsp_item_t      rsp_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [PW-1:0]                    sp_reg, sp_next;
    logic [DATA_WIDTH-1:0]            top_reg, top_next;
    logic [rpn_pkg::STATUS_WIDTH-1:0] status_reg, status_next;
    logic [rpn_pkg::OP_WIDTH-1:0]     op_reg, op_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    rpn_pkg::rsp_item_t               rsp_data_reg, rsp_data_next;

    logic [DATA_WIDTH-1:0]            stack_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]            rd_data_reg;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [DATA_WIDTH-1:0]            mem_wdata;
    logic [PW-1:0]                    sp_m2;

    logic [63:0]                      push_sext;
    logic [DATA_WIDTH-1:0]            push_word;
    logic [DATA_WIDTH+31:0]           top_pad;
    logic [PW+6:0]                    sp_pad;

    rpn_pkg::alu_req_t                alu_req;
    logic                             alu_done;
    logic [DATA_WIDTH-1:0]            alu_result;

    rpn_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .lhs    (rd_data_reg),
        .rhs    (top_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        push_sext = {{32{cmd_data.push_value[31]}}, cmd_data.push_value};
        push_word = push_sext[DATA_WIDTH-1:0];
        sp_m2     = sp_reg - PW'(2);
        top_pad   = {32'b0, top_reg};
        sp_pad    = {7'b0, sp_reg};
    end

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        status_next    = status_reg;
        op_next        = op_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = sp_m2[AW-1:0];
        mem_wdata      = '0;
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = cmd_data.operation;
                    status_next = rpn_pkg::ST_OK;
                    state_next  = S_EMIT;
                    case (cmd_data.operation)
                        rpn_pkg::OP_PUSH:
                        begin
                            if (sp_reg == PW'(STACK_DEPTH))
                            begin
                                status_next = rpn_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = sp_reg[AW-1:0];
                                mem_wdata = push_word;
                                top_next  = push_word;
                                sp_next   = sp_reg + 1'b1;
                            end
                        end
                        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                        rpn_pkg::OP_DIV, rpn_pkg::OP_REM:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = rpn_pkg::ST_UNDERFLOW;
                            end
                            else if (sp_reg == PW'(1))
                            begin
                                // lone entry is dropped
                                sp_next     = '0;
                                top_next    = '0;
                                status_next = rpn_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // rd_data_reg now holds the entry under the top
                if ((op_reg inside {rpn_pkg::OP_DIV, rpn_pkg::OP_REM}) && (top_reg == '0))
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = '0;
                    top_next    = '0;
                    sp_next     = sp_reg - 1'b1;
                    status_next = rpn_pkg::ST_DIV_ZERO;
                    state_next  = S_EMIT;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = S_CALC;
                end
            end
            S_CALC:
            begin
                if (alu_done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = alu_result;
                    top_next   = alu_result;
                    sp_next    = sp_reg - 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.top_value   = top_pad[31:0];
                    rsp_data_next.stack_depth = sp_pad[6:0];
                    rsp_data_next.status      = status_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[sp_m2[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            top_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        op_reg       <= op_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/rpn_alu.sv
// Serial arithmetic unit: bit-serial add/subtract, shift-add multiply,
// restoring signed divide/remainder, one bit per cycle.
// Depends on rpn_pkg.
`default_nettype none

module rpn_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rpn_pkg::alu_req_t     req,
    input  wire logic [DATA_WIDTH-1:0] lhs,
    input  wire logic [DATA_WIDTH-1:0] rhs,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      result
);

    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [2:0] A_IDLE  = 3'd0;
    localparam logic [2:0] A_SETUP = 3'd1;
    localparam logic [2:0] A_RUN   = 3'd2;
    localparam logic [2:0] A_FIX   = 3'd3;
    localparam logic [2:0] A_DONE  = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [rpn_pkg::OP_WIDTH-1:0]   op_reg, op_next;
    logic [DATA_WIDTH-1:0]          a_reg, a_next;
    logic [DATA_WIDTH-1:0]          b_reg, b_next;
    logic [DATA_WIDTH-1:0]          acc_reg, acc_next;
    logic [DATA_WIDTH-1:0]          rem_reg, rem_next;
    logic                           carry_reg, carry_next;
    logic                           neg_q_reg, neg_q_next;
    logic                           neg_r_reg, neg_r_next;

    logic                           b_bit;
    logic                           sum_bit;
    logic [DATA_WIDTH:0]            shifted;
    logic [DATA_WIDTH+1:0]          diff;
    logic                           q_bit;

    always_comb
    begin
        b_bit   = b_reg[0] ^ (op_reg == rpn_pkg::OP_SUB);
        sum_bit = a_reg[0] ^ b_bit ^ carry_reg;
        shifted = {rem_reg, a_reg[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, b_reg};
        q_bit   = ~diff[DATA_WIDTH+1];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        carry_next = carry_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    a_next     = lhs;
                    b_next     = rhs;
                    acc_next   = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    carry_next = (req.op == rpn_pkg::OP_SUB);
                    state_next = A_SETUP;
                end
            end
            A_SETUP:
            begin
                // divide works on magnitudes, signs restored at the end
                if (op_reg inside {rpn_pkg::OP_DIV, rpn_pkg::OP_REM})
                begin
                    neg_q_next = a_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1];
                    neg_r_next = a_reg[DATA_WIDTH-1];
                    a_next = a_reg[DATA_WIDTH-1] ? (~a_reg + 1'b1) : a_reg;
                    b_next = b_reg[DATA_WIDTH-1] ? (~b_reg + 1'b1) : b_reg;
                end
                state_next = A_RUN;
            end
            A_RUN:
            begin
                case (op_reg)
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB:
                    begin
                        acc_next   = {sum_bit, acc_reg[DATA_WIDTH-1:1]};
                        carry_next = (a_reg[0] & b_bit) | (carry_reg & (a_reg[0] ^ b_bit));
                        a_next     = a_reg >> 1;
                        b_next     = b_reg >> 1;
                    end
                    rpn_pkg::OP_MUL:
                    begin
                        if (b_reg[0])
                        begin
                            acc_next = acc_reg + a_reg;
                        end
                        a_next = a_reg << 1;
                        b_next = b_reg >> 1;
                    end
                    rpn_pkg::OP_DIV, rpn_pkg::OP_REM:
                    begin
                        rem_next = q_bit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
                        a_next   = {a_reg[DATA_WIDTH-2:0], q_bit};
                    end
                    default:
                    begin
                    end
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DATA_WIDTH - 1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                case (op_reg)
                    rpn_pkg::OP_DIV: acc_next = neg_q_reg ? (~a_reg + 1'b1) : a_reg;
                    rpn_pkg::OP_REM: acc_next = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
                    default:         acc_next = acc_reg;
                endcase
                state_next = A_DONE;
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        carry_reg <= carry_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done   = (state_reg == A_DONE);
    assign result = acc_reg;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for rpn_stack_calculator: a directed table, then random RPN traffic.
// Expected results come from the directed table or an in-bench stack predictor and are checked in arrival order.
// Depends on rpn_pkg and the rpn_stack_calculator RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int STACK_ENTRIES = 64;
    localparam int RANDOM_ITEMS  = 850;
    localparam int CLIMB_ITEMS   = 70;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = 100;
    localparam int TIMEOUT_NS    = 5_000_000;

    // codes past OP_REM are no-ops in the block
    localparam logic [OP_WIDTH-1:0] OP_NOP_6 = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_NOP_7 = 3'd7;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        cmd_item_t cmd;
        logic      has_rsp;
        rsp_item_t rsp;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 25;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{OP_ADD,   32'sd0},   1'b1, '{32'sd0,   7'd0, ST_UNDERFLOW}},
        '{'{OP_PUSH,  32'sd7},   1'b1, '{32'sd7,   7'd1, ST_OK}},
        '{'{OP_SUB,   32'sd0},   1'b1, '{32'sd0,   7'd0, ST_UNDERFLOW}},
        '{'{OP_MUL,   32'sd0},   1'b1, '{32'sd0,   7'd0, ST_UNDERFLOW}},
        '{'{OP_PUSH,  VAL_MAX},  1'b1, '{VAL_MAX,  7'd1, ST_OK}},
        '{'{OP_PUSH,  32'sd1},   1'b1, '{32'sd1,   7'd2, ST_OK}},
        '{'{OP_ADD,   32'sd0},   1'b1, '{VAL_MIN,  7'd1, ST_OK}},
        '{'{OP_PUSH,  -32'sd1},  1'b1, '{-32'sd1,  7'd2, ST_OK}},
        '{'{OP_DIV,   32'sd0},   1'b1, '{VAL_MIN,  7'd1, ST_OK}},
        '{'{OP_PUSH,  -32'sd1},  1'b1, '{-32'sd1,  7'd2, ST_OK}},
        '{'{OP_REM,   32'sd0},   1'b1, '{32'sd0,   7'd1, ST_OK}},
        '{'{OP_PUSH,  32'sd0},   1'b1, '{32'sd0,   7'd2, ST_OK}},
        '{'{OP_DIV,   32'sd0},   1'b1, '{32'sd0,   7'd1, ST_DIV_ZERO}},
        '{'{OP_PUSH,  -32'sd7},  1'b1, '{-32'sd7,  7'd2, ST_OK}},
        '{'{OP_PUSH,  32'sd2},   1'b1, '{32'sd2,   7'd3, ST_OK}},
        '{'{OP_REM,   32'sd0},   1'b0, '0},
        '{'{OP_PUSH,  32'sd0},   1'b1, '{32'sd0,   7'd3, ST_OK}},
        '{'{OP_REM,   32'sd0},   1'b1, '{32'sd0,   7'd2, ST_DIV_ZERO}},
        '{'{OP_NOP_6, VAL_MAX},  1'b0, '0},
        '{'{OP_NOP_7, VAL_MIN},  1'b0, '0},
        '{'{OP_PUSH,  VAL_MIN},  1'b0, '0},
        '{'{OP_PUSH,  -32'sd3},  1'b0, '0},
        '{'{OP_MUL,   32'sd0},   1'b0, '0},
        '{'{OP_PUSH,  -32'sd100}, 1'b0, '0},
        '{'{OP_SUB,   32'sd0},   1'b0, '0}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_data  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_data;

    logic signed [VALUE_WIDTH-1:0] calc_stack [STACK_ENTRIES];
    int                            calc_depth = 0;
    rsp_item_t                     pending_results [$];
    int                            mismatch_count = 0;
    int                            sender_burst_left = 0;

    rpn_stack_calculator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_item_t predict_rpn_step(input cmd_item_t c);
        logic signed [VALUE_WIDTH-1:0] lhs;
        logic signed [VALUE_WIDTH-1:0] rhs;
        logic signed [VALUE_WIDTH-1:0] res;
        rsp_item_t                     r;
        r = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_PUSH:
            begin
                if (calc_depth >= STACK_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    calc_stack[calc_depth] = c.push_value;
                    calc_depth++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM:
            begin
                if (calc_depth < 2)
                begin
                    // a lone entry is consumed, nothing goes back
                    calc_depth = 0;
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    rhs = calc_stack[calc_depth-1];
                    lhs = calc_stack[calc_depth-2];
                    case (c.operation)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        default:
                        begin
                            if (rhs == 0)
                            begin
                                res = '0;
                                r.status = ST_DIV_ZERO;
                            end
                            else if (rhs == -1)
                                // most negative / -1 wraps instead of trapping
                                res = (c.operation == OP_DIV) ? -lhs : '0;
                            else
                                res = (c.operation == OP_DIV) ? lhs / rhs : lhs % rhs;
                        end
                    endcase
                    calc_depth--;
                    calc_stack[calc_depth-1] = res;
                end
            end
            default: ;
        endcase
        if (calc_depth > 0)
            r.top_value = calc_stack[calc_depth-1];
        r.stack_depth = DEPTH_WIDTH'(calc_depth);
        return r;
    endfunction

    // Offer one command, wait for the transaction, then apply burst/gap pacing.
    task automatic send_cmd(input cmd_item_t c, input logic has_rsp, input rsp_item_t fixed_rsp);
        rsp_item_t predicted;
        int        gap;
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = predict_rpn_step(c);
        pending_results.push_back(has_rsp ? fixed_rsp : predicted);
        sender_burst_left--;
        if (sender_burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
            end
            sender_burst_left = $urandom_range(1, 40);
        end
    endtask

    initial
    begin : stimulus
        cmd_item_t c;
        int        item_idx;
        int        seg_left;
        int        push_pct;
        int        pick;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        sender_burst_left = $urandom_range(1, 40);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].has_rsp, DIRECTED_ROWS[i].rsp);

        // open with a straight climb past full, then mixed segments
        item_idx = 0;
        seg_left = CLIMB_ITEMS;
        push_pct = 100;
        while (item_idx < RANDOM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 55;
                    default: push_pct = 25;
                endcase
            end
            seg_left--;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c.push_value = $urandom;
                4, 5, 6: c.push_value = $signed($urandom_range(0, 20)) - 10;
                7: c.push_value = VAL_MIN;
                8: c.push_value = VAL_MAX;
                default: c.push_value = ($urandom_range(0, 1) == 0) ? 32'sd0 : -32'sd1;
            endcase
            if ($urandom_range(0, 99) < push_pct)
                c.operation = OP_PUSH;
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 18)
                    c.operation = OP_WIDTH'(OP_ADD + pick % 5);
                else if (pick == 18)
                    c.operation = OP_NOP_6;
                else
                    c.operation = OP_NOP_7;
            end
            send_cmd(c, 1'b0, '0);
            item_idx++;
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : rsp_stall_gen
        int pattern;
        int run_len;
        int pass_count;
        wait (rst_n);
        pass_count = 0;
        forever
        begin
            pass_count++;
            // one long hold-off: output reg and command slot fill, cmd_stall backs up
            if (pass_count == 12)
            begin
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    rsp_stall <= 1'b1;
                end
            end
            pattern = $urandom_range(0, 3);
            run_len = $urandom_range(10, 150);
            repeat (run_len)
            begin
                @(negedge clk);
                case (pattern)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= ~rsp_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : rsp_check
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response with no pending command: top_value %0d depth %0d status %0d",
                       rsp_data.top_value, rsp_data.stack_depth, rsp_data.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_data.top_value !== want.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d",
                           want.top_value, rsp_data.top_value);
                    mismatch_count++;
                end
                if (rsp_data.stack_depth !== want.stack_depth)
                begin
                    $error("stack_depth: expected %0d, actual %0d",
                           want.stack_depth, rsp_data.stack_depth);
                    mismatch_count++;
                end
                if (rsp_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_alu.sv
rtl/core/rpn_stack_calculator.sv
test/testbench.sv
